### rtl/swsp_pkg.sv
// Package with the word types and character constants of the shell word splitter.
`default_nettype none

package swsp_pkg;

  localparam logic [7:0] CH_BSL  = 8'h5C;
  localparam logic [7:0] CH_SQ   = 8'h27;
  localparam logic [7:0] CH_DQ   = 8'h22;
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] SEP_RST = 8'h20;

  localparam logic MODE_CHAR = 1'b0;
  localparam logic MODE_END  = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] char_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       char_present;
    logic       word_end;
    logic       cmd_end;
  } out_word_t;

endpackage

`default_nettype wire

### rtl/shell_word_splitter.sv
// Top level of the shell word splitter: parse state, result register and skid stage.
//
// The input channel (in_valid, in_ready, in_data) carries one command byte or an
// end marker per word. The output channel (out_valid, out_ready, out_data) carries
// at most one result per input word: a word character, a word end, or both, and
// the command end. Quotes, backslash escapes and the separator byte are handled
// as in a shell; the most recent word character is held back one word so that an
// escaped character inside quotes can replace it.
// One input word is accepted every cycle while in_ready is high. A result is registered
// in the output register, or in the skid register while the output is stalled. The parse
// state is updated in the same cycle as the accept, so consecutive words need no gap.
// When the receiver stalls, one further result is caught in a skid register and
// in_ready drops until the skid register drains.
// Reset clears the parse state and both output valid flags and sets the separator to a
// space. The user writes the separator through cfg_we and cfg_wdata only while idle; the block does not enforce it.
`default_nettype none

module shell_word_splitter (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire swsp_pkg::in_word_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output swsp_pkg::out_word_t     out_data,
  input  wire logic               cfg_we,
  input  wire logic [7:0]         cfg_wdata
);
  import swsp_pkg::*;

  logic [7:0] sep_val_r;
  logic       in_single_r, in_single_nxt;
  logic       in_double_r, in_double_nxt;
  logic       after_bsl_r, after_bsl_nxt;
  logic       after_cq_r, after_cq_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic [7:0] held_char_r, held_char_nxt;

  out_word_t  out_r, skid_r, res;
  logic       out_valid_r, skid_valid_r;
  logic       has_res;
  logic       in_fire, out_fire, is_end;
  logic [7:0] c;

  assign c        = in_data.char_in;
  assign is_end   = (in_data.mode == MODE_END) || (c == CH_NUL);
  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_fire  = out_valid_r && out_ready;

  always_comb begin
    logic done;
    logic add;
    done           = 1'b0;
    add            = 1'b0;
    in_single_nxt  = in_single_r;
    in_double_nxt  = in_double_r;
    after_bsl_nxt  = after_bsl_r;
    after_cq_nxt   = after_cq_r;
    held_valid_nxt = held_valid_r;
    held_char_nxt  = held_char_r;
    has_res        = 1'b0;
    res            = '0;
    if (is_end) begin
      has_res          = 1'b1;
      res.char_out     = held_valid_r ? held_char_r : 8'h00;
      res.char_present = held_valid_r;
      res.word_end     = held_valid_r;
      res.cmd_end      = 1'b1;
      in_single_nxt    = 1'b0;
      in_double_nxt    = 1'b0;
      after_bsl_nxt    = 1'b0;
      after_cq_nxt     = 1'b0;
      held_valid_nxt   = 1'b0;
      held_char_nxt    = 8'h00;
    end else begin
      if (in_single_r) begin
        if (after_bsl_r) begin
          after_bsl_nxt = 1'b0;
          if (c == CH_BSL) begin
            done = 1'b1;
          end else if (c == CH_SQ) begin
            held_char_nxt  = c;
            held_valid_nxt = 1'b1;
            done           = 1'b1;
          end
        end
        if (!done && c == CH_SQ) begin
          in_single_nxt = 1'b0;
          after_cq_nxt  = 1'b1;
          done          = 1'b1;
        end
      end else if (in_double_r) begin
        if (after_bsl_r) begin
          after_bsl_nxt  = 1'b0;
          held_char_nxt  = c;
          held_valid_nxt = 1'b1;
          done           = 1'b1;
        end else if (c == CH_DQ) begin
          in_double_nxt = 1'b0;
          after_cq_nxt  = 1'b1;
          done          = 1'b1;
        end
      end
      if (!done) begin
        after_cq_nxt = 1'b0;
        if (c == CH_BSL) begin
          after_bsl_nxt = 1'b1;
          add           = 1'b1;
        end else if (c == CH_SQ) begin
          in_single_nxt = 1'b1;
        end else if (c == CH_DQ) begin
          if (!in_single_r) begin
            in_double_nxt = 1'b1;
          end else begin
            add = 1'b1;
          end
        end else if (in_single_r || in_double_r) begin
          add = 1'b1;
        end else if (c == sep_val_r) begin
          if (held_valid_r || after_cq_r) begin
            has_res          = 1'b1;
            res.char_out     = held_valid_r ? held_char_r : 8'h00;
            res.char_present = held_valid_r;
            res.word_end     = 1'b1;
            held_valid_nxt   = 1'b0;
            held_char_nxt    = 8'h00;
          end
        end else begin
          add = 1'b1;
        end
        if (add) begin
          if (held_valid_r) begin
            has_res          = 1'b1;
            res.char_out     = held_char_r;
            res.char_present = 1'b1;
          end
          held_char_nxt  = c;
          held_valid_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_val_r    <= SEP_RST;
      in_single_r  <= 1'b0;
      in_double_r  <= 1'b0;
      after_bsl_r  <= 1'b0;
      after_cq_r   <= 1'b0;
      held_valid_r <= 1'b0;
      held_char_r  <= 8'h00;
    end else begin
      if (cfg_we) begin
        sep_val_r <= cfg_wdata;
      end
      if (in_fire) begin
        in_single_r  <= in_single_nxt;
        in_double_r  <= in_double_nxt;
        after_bsl_r  <= after_bsl_nxt;
        after_cq_r   <= after_cq_nxt;
        held_valid_r <= held_valid_nxt;
        held_char_r  <= held_char_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire && has_res) begin
      if (out_valid_r && !out_fire) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (in_fire && has_res) begin
      if (out_valid_r && !out_fire) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("Skid register holds a word while the output register is empty.");

  a_held_char_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !held_valid_r |-> (held_char_r == 8'h00))
    else $error("Held character is nonzero while nothing is held.");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_end) |=> (!held_valid_r && !in_single_r && !in_double_r
                             && !after_bsl_r && !after_cq_r))
    else $error("Parse state not cleared after the end of a command.");

  a_absent_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.char_present) |-> (out_r.char_out == 8'h00))
    else $error("Result carries a character byte without a character.");

endmodule

`default_nettype wire

### sim/tb_shell_word_splitter.sv
// Testbench for the shell word splitter: a predicting scoreboard, valid/ready drivers and phases.
`default_nettype none

module tb_shell_word_splitter;
  timeunit 1ns;
  timeprecision 1ps;

  import swsp_pkg::*;

  class split_scoreboard;
    logic [7:0] sep;
    bit         single_q;
    bit         double_q;
    bit         bsl_q;
    bit         closed_q;
    bit         held_v;
    logic [7:0] held_c;
    out_word_t  pending_words[$];
    int         errors;
    int         n_checked;

    function new();
      sep = SEP_RST;
      errors = 0;
      n_checked = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      single_q = 1'b0;
      double_q = 1'b0;
      bsl_q    = 1'b0;
      closed_q = 1'b0;
      held_v   = 1'b0;
      held_c   = 8'h00;
    endfunction

    function int pending();
      return pending_words.size();
    endfunction

    // Holds the new character back and releases the one held before, if any.
    function bit push_char(input logic [7:0] c, output out_word_t r);
      bit emit;
      emit = held_v;
      r = '0;
      if (held_v) begin
        r.char_out = held_c;
        r.char_present = 1'b1;
      end
      held_c = c;
      held_v = 1'b1;
      return emit;
    endfunction

    function void note_input(input in_word_t w);
      out_word_t  r;
      bit         emit;
      bit         done;
      logic [7:0] c;
      emit = 1'b0;
      done = 1'b0;
      r = '0;
      c = w.char_in;
      if (w.mode == MODE_END || c == CH_NUL) begin
        r.char_out = held_v ? held_c : 8'h00;
        r.char_present = held_v;
        r.word_end = held_v;
        r.cmd_end = 1'b1;
        emit = 1'b1;
        clear_parse();
      end else begin
        if (single_q) begin
          if (bsl_q) begin
            bsl_q = 1'b0;
            if (c == CH_BSL) begin
              done = 1'b1;
            end else if (c == CH_SQ) begin
              held_c = c;
              held_v = 1'b1;
              done = 1'b1;
            end
          end
          if (!done && c == CH_SQ) begin
            single_q = 1'b0;
            closed_q = 1'b1;
            done = 1'b1;
          end
        end else if (double_q) begin
          if (bsl_q) begin
            bsl_q = 1'b0;
            held_c = c;
            held_v = 1'b1;
            done = 1'b1;
          end else if (c == CH_DQ) begin
            double_q = 1'b0;
            closed_q = 1'b1;
            done = 1'b1;
          end
        end
        if (!done) begin
          if (c == CH_BSL) begin
            bsl_q = 1'b1;
            emit = push_char(c, r);
          end else if (c == CH_SQ) begin
            single_q = 1'b1;
          end else if (c == CH_DQ) begin
            if (!single_q) double_q = 1'b1;
            else emit = push_char(c, r);
          end else if (single_q || double_q) begin
            emit = push_char(c, r);
          end else if (c == sep) begin
            if (held_v || closed_q) begin
              r.char_out = held_v ? held_c : 8'h00;
              r.char_present = held_v;
              r.word_end = 1'b1;
              emit = 1'b1;
              held_v = 1'b0;
              held_c = 8'h00;
            end
          end else begin
            emit = push_char(c, r);
          end
          closed_q = 1'b0;
        end
      end
      if (emit) pending_words.push_back(r);
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= 50) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_result(input out_word_t got);
      out_word_t exp_w;
      bit        bad;
      if (pending_words.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      exp_w = pending_words.pop_front();
      n_checked++;
      bad = 1'b0;
      if (got.char_out !== exp_w.char_out) bad = 1'b1;
      if (got.char_present !== exp_w.char_present) bad = 1'b1;
      if (got.word_end !== exp_w.word_end) bad = 1'b1;
      if (got.cmd_end !== exp_w.cmd_end) bad = 1'b1;
      if (bad) begin
        report($sformatf("got char %h present %b wend %b cend %b, want %h %b %b %b",
                         got.char_out, got.char_present, got.word_end, got.cmd_end,
                         exp_w.char_out, exp_w.char_present, exp_w.word_end,
                         exp_w.cmd_end));
      end
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_word_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_word_t  out_data;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  split_scoreboard sb;
  bit calm;
  int n_sent;
  int n_cmds;
  int n_seps;

  shell_word_splitter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  function automatic int idle_draw();
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = idle_draw();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_word(input in_word_t w);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    n_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_char(input logic [7:0] c);
    in_word_t w;
    w.mode = MODE_CHAR;
    w.char_in = c;
    send_word(w);
  endtask

  task automatic send_end(input logic [7:0] c);
    in_word_t w;
    w.mode = MODE_END;
    w.char_in = c;
    n_cmds++;
    send_word(w);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // A word with no result may still be in flight, so the task keeps waiting after the drain.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_sep(input logic [7:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.sep = v;
    n_seps++;
  endtask

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 8'(8'h61 + $urandom_range(0, 3));
    if (r < 55) return sb.sep;
    if (r < 67) return CH_SQ;
    if (r < 79) return CH_DQ;
    if (r < 89) return CH_BSL;
    if (r < 98) return 8'($urandom_range(1, 255));
    return CH_NUL;
  endfunction

  task automatic random_command();
    int len;
    len = $urandom_range(0, 20);
    calm = ($urandom_range(0, 3) == 0);
    repeat (len) send_char(rand_byte());
    send_end(8'($urandom_range(0, 255)));
  endtask

  initial begin
    logic [7:0] seps[7];
    int target;
    seps = '{8'h2C, 8'h00, 8'hFF, CH_SQ, CH_BSL, CH_DQ, SEP_RST};
    sb = new();
    calm = 1'b1;
    n_sent = 0;
    n_cmds = 0;
    n_seps = 1;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = 8'h00;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty quotes, a run of separators, a stale backslash and an override with nothing held.
    send_text("''  \\ \"x\"");
    send_end(8'hA5);
    // Escaped quote inside single quotes, a single quote inside double quotes, byte 255.
    calm = 1'b0;
    send_text("'\\''\"'y\"");
    send_char(8'hFF);
    send_char(CH_NUL);
    // Closed empty quote right before the end.
    send_text("\"\"");
    send_end(8'h00);

    target = 200;
    while (n_sent < target) random_command();
    wait_idle();
    foreach (seps[i]) begin
      write_sep(seps[i]);
      target += 175;
      while (n_sent < target) begin
        random_command();
        if ($urandom_range(0, 9) == 0) wait_idle();
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    $display("Sent %0d words in %0d commands under %0d separator settings;", n_sent, n_cmds,
             n_seps);
    $display("%0d results were checked against the prediction.", sb.n_checked);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
rtl/swsp_pkg.sv
rtl/shell_word_splitter.sv
sim/tb_shell_word_splitter.sv
